>>> design/tria_pkg.sv
// ----------------------------------------------------------------------------
// tria_pkg
// shared types and constants of the two resource interval assigner
// ----------------------------------------------------------------------------
package tria_pkg;

  localparam int unsigned MaxIntervals = 64;
  localparam int unsigned TimeW        = 16;
  localparam int unsigned IndexW       = 6;

  typedef struct packed {
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] end_time;
    logic             last_interval;
  } in_t;

  typedef struct packed {
    logic [IndexW-1:0] item_index;
    logic              resource;
    logic              impossible;
    logic              last_result;
  } out_t;

  typedef struct packed {
    logic [TimeW-1:0]  end_time;
    logic [TimeW-1:0]  start_time;
    logic [IndexW-1:0] idx;
  } slot_t;

  // sorted head offered by the front part
  typedef struct packed {
    logic  valid;
    logic  last;
    slot_t slot;
  } head_t;

  // true when slot a sorts strictly after key (end, start)
  function automatic logic slot_after(slot_t a, logic [TimeW-1:0] e, logic [TimeW-1:0] s);
    logic r;
    if (a.end_time != e) r = (a.end_time > e);
    else                 r = (a.start_time > s);
    return r;
  endfunction

endpackage

>>> design/tria_ram.sv
// ----------------------------------------------------------------------------
// tria_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module tria_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/tria_sorter.sv
// ----------------------------------------------------------------------------
// tria_sorter
// front part: systolic insertion sort, then shifts the sorted set out
// ----------------------------------------------------------------------------
module tria_sorter import tria_pkg::*; #(
  parameter int unsigned MAX_INTERVALS = MaxIntervals,
  localparam int unsigned CntW = $clog2(MAX_INTERVALS + 1)
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  in_t   in_item_i,
  output head_t head_o,
  input  logic  pop_i
);

  typedef enum logic {
    COLLECT,
    DRAIN
  } state_e;

  state_e state_q;
  logic [CntW-1:0] count_q;
  slot_t cell_q [MAX_INTERVALS];
  slot_t cell_d [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] aft;
  slot_t key;
  logic acc;

  assign in_stall_o = (state_q != COLLECT);
  assign acc        = in_valid_i && (state_q == COLLECT);

  always_comb begin
    key.end_time   = in_item_i.end_time;
    key.start_time = in_item_i.start_time;
    key.idx        = IndexW'(count_q);
  end

  always_comb begin
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      if (CntW'(i) < count_q) aft[i] = slot_after(cell_q[i], key.end_time, key.start_time);
      else                    aft[i] = (CntW'(i) == count_q);
    end
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      cell_d[i] = cell_q[i];
      if (state_q == DRAIN) begin
        if (i + 1 < MAX_INTERVALS) cell_d[i] = cell_q[(i + 1) % MAX_INTERVALS];
      end else if (aft[i]) begin
        if (i > 0 && aft[(i + MAX_INTERVALS - 1) % MAX_INTERVALS]) begin
          cell_d[i] = cell_q[(i + MAX_INTERVALS - 1) % MAX_INTERVALS];
        end else begin
          cell_d[i] = key;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc || (state_q == DRAIN && pop_i)) begin
      cell_q <= cell_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= COLLECT;
      count_q <= '0;
    end else begin
      case (state_q)
        COLLECT: begin
          if (acc) begin
            count_q <= count_q + CntW'(1);
            if (in_item_i.last_interval || (count_q == CntW'(MAX_INTERVALS - 1))) begin
              state_q <= DRAIN;
            end
          end
        end
        DRAIN: begin
          if (pop_i) begin
            count_q <= count_q - CntW'(1);
            if (count_q == CntW'(1)) state_q <= COLLECT;
          end
        end
        default: state_q <= COLLECT;
      endcase
    end
  end

  assign head_o.valid = (state_q == DRAIN);
  assign head_o.last  = (count_q == CntW'(1));
  assign head_o.slot  = cell_q[0];

endmodule

>>> design/tria_back.sv
// ----------------------------------------------------------------------------
// tria_back
// back part: greedy walk over the sorted set, then one impossible item or the results in arrival order
// ----------------------------------------------------------------------------
module tria_back import tria_pkg::*; #(
  parameter int unsigned MAX_INTERVALS = MaxIntervals,
  localparam int unsigned CntW  = $clog2(MAX_INTERVALS + 1),
  localparam int unsigned AddrW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  head_t head_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output out_t  out_item_o
);

  typedef enum logic [1:0] {
    WALK,
    IMP,
    EMIT
  } state_e;

  state_e state_q;
  logic [TimeW-1:0] ff0_q, ff1_q;
  logic fail_q, fail_now, res;
  logic [CntW-1:0] n_q, e_q;
  logic rv_q, rlast_q;
  logic [AddrW-1:0] ridx_q;
  out_t fifo_q [2];
  logic [1:0] fcnt_q;
  logic wp_q, rp_q;
  logic push, popo, credit, issue, we;
  out_t push_item;
  logic [AddrW-1:0] addr;
  logic rdata;
  logic f0, f1;

  assign pop_o = head_i.valid && (state_q == WALK);

  always_comb begin
    f0 = head_i.slot.start_time >= ff0_q;
    f1 = head_i.slot.start_time >= ff1_q;
    fail_now = !f0 && !f1;
    if (f0 && f1) res = (ff0_q > ff1_q) ? 1'b0 : 1'b1;
    else          res = !f0;
  end

  assign we     = pop_o && !fail_q && !fail_now;
  assign credit = ({1'b0, fcnt_q} + {2'b0, rv_q}) < 3'd2;
  assign issue  = (state_q == EMIT) && credit;
  assign addr   = (state_q == EMIT) ? e_q[AddrW-1:0] : head_i.slot.idx[AddrW-1:0];

  tria_ram #(.Width(1), .Depth(MAX_INTERVALS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (res),
    .rdata_o (rdata)
  );

  always_comb begin
    push = 1'b0;
    push_item = '0;
    if (rv_q) begin
      push = 1'b1;
      push_item.item_index  = IndexW'(ridx_q);
      push_item.resource    = rdata;
      push_item.last_result = rlast_q;
    end else if (state_q == IMP && credit) begin
      push = 1'b1;
      push_item.impossible  = 1'b1;
      push_item.last_result = 1'b1;
    end
  end

  assign out_valid_o = (fcnt_q != 2'd0);
  assign out_item_o  = fifo_q[rp_q];
  assign popo        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= push_item;
    if (issue) begin
      ridx_q  <= e_q[AddrW-1:0];
      rlast_q <= (e_q == n_q - CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WALK;
      ff0_q   <= '0;
      ff1_q   <= '0;
      fail_q  <= 1'b0;
      n_q     <= '0;
      e_q     <= '0;
      rv_q    <= 1'b0;
      fcnt_q  <= '0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
    end else begin
      rv_q <= issue;
      if (push) wp_q <= !wp_q;
      if (popo) rp_q <= !rp_q;
      fcnt_q <= fcnt_q + {1'b0, push} - {1'b0, popo};
      case (state_q)
        WALK: begin
          if (pop_o) begin
            n_q <= n_q + CntW'(1);
            if (!fail_q && fail_now) fail_q <= 1'b1;
            if (head_i.last) begin
              ff0_q   <= '0;
              ff1_q   <= '0;
              e_q     <= '0;
              state_q <= (fail_q || fail_now) ? IMP : EMIT;
            end else if (we) begin
              if (res) ff1_q <= head_i.slot.end_time;
              else     ff0_q <= head_i.slot.end_time;
            end
          end
        end
        IMP: begin
          if (credit) begin
            fail_q  <= 1'b0;
            n_q     <= '0;
            state_q <= WALK;
          end
        end
        EMIT: begin
          if (issue) begin
            e_q <= e_q + CntW'(1);
            if (e_q == n_q - CntW'(1)) begin
              n_q     <= '0;
              state_q <= WALK;
            end
          end
        end
        default: state_q <= WALK;
      endcase
    end
  end

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= 2'd2) else $error("result queue overflow");
  a_no_write_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == EMIT |-> !we) else $error("ram write during emit");
  a_imp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.impossible |-> out_item_o.last_result)
    else $error("impossible result not last");
  a_read_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> push) else $error("read data lost");

endmodule

>>> design/two_resource_interval_assigner.sv
// ----------------------------------------------------------------------------
// two_resource_interval_assigner
// assigns a set of intervals to two resources by greedy walk over end order
// ----------------------------------------------------------------------------
// input channel: one interval per item (start, end, last flag); one item a
// cycle is taken while a set is collected, each inserted into a sorted row
// of cells in the cycle it arrives. last_interval, or a full row, closes it.
// the sorted row then shifts out one entry a cycle into the greedy walk,
// while the back part is walking; no input is taken during that walk.
// output channel: n assignment items in arrival order from the assignment
// ram, each read only while the result queue has room for it, or a single
// impossible item; last_result marks the end. the next set may be collected
// while the results of the previous one are still going out. a stall on the
// output holds the two-entry result queue and, once the queue and any read
// in flight fill it, the emit pass. reset empties the set and the queue;
// the assignment ram needs no clearing.
// ----------------------------------------------------------------------------
module two_resource_interval_assigner import tria_pkg::*; #(
  parameter int unsigned MAX_INTERVALS = MaxIntervals
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_item_o
);

  head_t head;
  logic  pop;

  tria_sorter #(.MAX_INTERVALS(MAX_INTERVALS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  tria_back #(.MAX_INTERVALS(MAX_INTERVALS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
